// ===== design/fat12_cluster_chain_walker_top_defines.svh =====
// assertion macros for the fat12 cluster chain walker checker
// expects clk and arst_n to be visible where the macros are used
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define FCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fcw_pkg.sv =====
// shared types, codes and constants of the fat12 cluster chain walker
// no dependencies
`default_nettype none

package fcw_pkg;

	localparam int DEF_TABLE_BYTES  = 512;
	localparam int DEF_SECTOR_BYTES = 512;

	localparam int CL_W    = 12;
	localparam int POS_W   = 13;
	localparam int SEC_W   = 16;
	localparam int SIZE_W  = 32;
	localparam int CNT_W   = 10;
	localparam int FUNC_W  = 2;
	localparam int TADDR_W = 9;
	localparam int CIDX_W  = 2;

	localparam logic [CL_W-1:0]  ENTRY_LAST = 12'hFFF;
	localparam logic [CL_W-1:0]  ENTRY_MIN  = 12'h002;
	localparam logic [CL_W-1:0]  ENTRY_MAX  = 12'hFEF;

	localparam logic [SEC_W-1:0] RST_DATA_START   = 16'd31;
	localparam logic [SEC_W-1:0] RST_SECTOR_LIMIT = 16'd4079;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_START   = 2'd1,
		FUNC_ADVANCE = 2'd2,
		FUNC_UNUSED  = 2'd3
	} fcw_func_t;

	localparam logic [CIDX_W-1:0] REG_DATA_START   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SECTOR_LIMIT = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD1,
		ST_FIN
	} fcw_state_t;

	// everything the step logic needs once both entry bytes are in
	typedef struct packed {
		logic [CL_W-1:0]   cluster;
		logic [SIZE_W-1:0] left;
		logic              del;
		logic              nowalk;
		logic              in_range;
		logic              odd;
		logic [7:0]        b0;
		logic [7:0]        b1;
		logic [SEC_W-1:0]  dss;
		logic [SEC_W-1:0]  limit;
	} fcw_step_req_t;

	typedef struct packed {
		logic [SEC_W-1:0]  sector;
		logic [CNT_W-1:0]  byte_count;
		logic              last;
		logic              no_walk;
		logic [CL_W-1:0]   next_cluster;
		logic [SIZE_W-1:0] new_left;
		logic              keep_active;
	} fcw_step_rsp_t;

endpackage

`default_nettype wire

// ===== design/fcw_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module fcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/fcw_step.sv =====
// entry decode, next cluster choice and end-of-walk decision for one step
// depends on fcw_pkg
`default_nettype none

module fcw_step
	import fcw_pkg::*;
#(
	parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
	input  wire fcw_step_req_t req,
	output fcw_step_rsp_t      rsp
);

	localparam logic [SIZE_W-1:0] SB = SIZE_W'(SECTOR_BYTES);

	logic [CL_W-1:0]   entry;
	logic [CL_W-1:0]   next;
	logic [SIZE_W-1:0] take;
	logic [SIZE_W-1:0] new_left;
	logic [SEC_W:0]    next_sec;
	logic              end_entry;
	logic              end_walk;

	always_comb begin
		// odd clusters sit in the high nibble of the first byte
		if (req.odd) begin
			entry = {req.b1, req.b0[7:4]};
		end else begin
			entry = {req.b1[3:0], req.b0};
		end

		take     = (req.left > SB) ? SB : req.left;
		new_left = req.left - take;

		if (req.del) begin
			next      = req.cluster + CL_W'(1);
			end_entry = !req.in_range || (entry != '0);
		end else begin
			next      = entry;
			end_entry = !req.in_range || (entry == ENTRY_LAST) ||
				(entry < ENTRY_MIN) || (entry > ENTRY_MAX);
		end

		next_sec = (SEC_W+1)'(next) + {1'b0, req.dss};
		end_walk = end_entry || (next_sec > {1'b0, req.limit}) || (new_left == '0);

		if (req.nowalk) begin
			rsp.sector      = '0;
			rsp.byte_count  = '0;
			rsp.last        = 1'b0;
			rsp.no_walk     = 1'b1;
			rsp.keep_active = 1'b0;
		end else begin
			rsp.sector      = SEC_W'(req.cluster) + req.dss;
			rsp.byte_count  = take[CNT_W-1:0];
			rsp.last        = end_walk;
			rsp.no_walk     = 1'b0;
			rsp.keep_active = !end_walk;
		end
		rsp.next_cluster = next;
		rsp.new_left     = new_left;
	end

endmodule

`default_nettype wire

// ===== design/fat12_cluster_chain_walker_top.sv =====
// top level of the fat12 cluster chain walker: control, walk state, output register
// depends on fcw_pkg, fcw_ram and fcw_step
`default_nettype none

// The walker keeps one sector of a packed 12-bit allocation table in a
// single-port ram (written with func 0) and follows a file's cluster chain,
// one data sector per start (func 1) or advance (func 2) transfer. A table
// write finishes in its transfer cycle. For a start or advance, the transfer
// cycle issues the read of the entry's first byte, the read state reads the
// second byte, and the finishing state decodes the entry and loads the output
// register; the single ram port is read twice per entry. The input is
// stalled in the read and finishing states, and the finishing state waits
// while the output register still holds a result that is stalled. The next
// item is taken while a result waits. Table bytes are undefined until
// written and there is no clearing pass after reset. Configuration writes
// are always ready and must come only while the walker is idle.
module fat12_cluster_chain_walker_top
	import fcw_pkg::*;
#(
	parameter int TABLE_BYTES  = DEF_TABLE_BYTES,
	parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [SEC_W-1:0]   cfg_data,

	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [TADDR_W-1:0] table_addr,
	input  wire logic [7:0]         table_byte,
	input  wire logic [CL_W-1:0]    start_cluster,
	input  wire logic [SIZE_W-1:0]  file_size,
	input  wire logic               deleted,

	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [SEC_W-1:0]        sector,
	output logic [CNT_W-1:0]        byte_count,
	output logic                    last,
	output logic                    no_walk
);

	localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
	localparam logic [POS_W:0] TB = (POS_W+1)'(TABLE_BYTES);

	// configuration registers
	logic [SEC_W-1:0]  dss_q;
	logic [SEC_W-1:0]  lim_q;

	// walk state
	logic [CL_W-1:0]   cur_q;
	logic [SIZE_W-1:0] left_q;
	logic              del_q;
	logic              active_q;

	// per-item working registers
	fcw_state_t        state_q;
	fcw_state_t        state_d;
	logic [POS_W-1:0]  pos_q;
	logic              odd_q;
	logic              inr_q;
	logic              nowalk_q;
	logic [7:0]        b0_q;

	// output register
	logic              out_valid_q;
	logic [SEC_W-1:0]  sector_q;
	logic [CNT_W-1:0]  count_q;
	logic              last_q;
	logic              nowalk_out_q;

	// request decode
	fcw_func_t         func_c;
	logic              in_xfer;
	logic              is_walk;
	logic              wr_ok;
	logic [CL_W-1:0]   base_cl;
	logic              base_del;
	logic [CL_W-1:0]   lk_cl;
	logic [POS_W-1:0]  lk_pos;
	logic [POS_W-1:0]  wr_pos;
	logic [POS_W-1:0]  pos_nx;

	// ram port
	logic              ram_en;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [7:0]        ram_rdata;

	logic              out_free;
	logic              fin_load;

	fcw_step_req_t     step_req;
	fcw_step_rsp_t     step_rsp;

	assign cfg_ready = 1'b1;
	assign func_c    = fcw_func_t'(func);
	assign in_xfer   = in_valid && !in_stall;
	assign is_walk   = (func_c == FUNC_START) || (func_c == FUNC_ADVANCE);
	assign wr_ok     = ((POS_W+1)'(table_addr) < TB);
	assign wr_pos    = POS_W'(table_addr);

	// cluster to look up: a start uses the request, an advance the walk state
	always_comb begin
		if (func_c == FUNC_START) begin
			base_cl  = start_cluster;
			base_del = deleted;
		end else begin
			base_cl  = cur_q;
			base_del = del_q;
		end
		// deleted mode checks the entry of the following cluster
		lk_cl  = base_del ? (base_cl + CL_W'(1)) : base_cl;
		// byte offset of a packed entry: three bytes per cluster pair
		lk_pos = POS_W'(lk_cl[CL_W-1:1]) + POS_W'({lk_cl[CL_W-1:1], 1'b0}) +
			POS_W'(lk_cl[0]);
	end

	assign pos_nx   = pos_q + POS_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && is_walk) begin
					state_d = ST_RD1;
				end
			end
			ST_RD1: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs: stall, ram port, result load
	always_comb begin
		in_stall = 1'b1;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = lk_pos[AW-1:0];
		fin_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (func_c == FUNC_WRITE)) begin
					ram_en   = wr_ok;
					ram_we   = 1'b1;
					ram_addr = wr_pos[AW-1:0];
				end else if (in_valid && is_walk) begin
					// first entry byte is read in the transfer cycle
					ram_en   = 1'b1;
					ram_addr = lk_pos[AW-1:0];
				end
			end
			ST_RD1: begin
				ram_en   = 1'b1;
				ram_addr = pos_nx[AW-1:0];
			end
			ST_FIN: begin
				fin_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	fcw_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_BYTES)
	) u_table (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (table_byte),
		.rdata (ram_rdata)
	);

	// second byte arrives straight from the ram in the finishing cycle
	assign step_req = '{
		cluster:  cur_q,
		left:     left_q,
		del:      del_q,
		nowalk:   nowalk_q,
		in_range: inr_q,
		odd:      odd_q,
		b0:       b0_q,
		b1:       ram_rdata,
		dss:      dss_q,
		limit:    lim_q
	};

	fcw_step #(
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_step (
		.req (step_req),
		.rsp (step_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dss_q <= RST_DATA_START;
			lim_q <= RST_SECTOR_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DATA_START) begin
				dss_q <= cfg_data;
			end else if (cfg_index == REG_SECTOR_LIMIT) begin
				lim_q <= cfg_data;
			end
		end
	end

	// control and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cur_q    <= '0;
			left_q   <= '0;
			del_q    <= 1'b0;
			active_q <= 1'b0;
			nowalk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && (func_c == FUNC_START)) begin
				// a start drops any walk in progress
				cur_q    <= start_cluster;
				left_q   <= file_size;
				del_q    <= deleted;
				active_q <= 1'b1;
				nowalk_q <= 1'b0;
			end else if (in_xfer && (func_c == FUNC_ADVANCE)) begin
				nowalk_q <= !active_q;
			end
			if (fin_load && !nowalk_q) begin
				left_q   <= step_rsp.new_left;
				active_q <= step_rsp.keep_active;
				if (step_rsp.keep_active) begin
					cur_q <= step_rsp.next_cluster;
				end
			end
		end
	end

	// entry position and first byte, payload only
	always_ff @(posedge clk) begin
		if (in_xfer && is_walk) begin
			pos_q <= lk_pos;
			odd_q <= lk_cl[0];
			inr_q <= ((POS_W+1)'(lk_pos) + (POS_W+1)'(1)) < TB;
		end
		if (state_q == ST_RD1) begin
			b0_q <= ram_rdata;
		end
	end

	// output register, parts the result side from the request side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			sector_q     <= step_rsp.sector;
			count_q      <= step_rsp.byte_count;
			last_q       <= step_rsp.last;
			nowalk_out_q <= step_rsp.no_walk;
		end
	end

	assign out_valid  = out_valid_q;
	assign sector     = sector_q;
	assign byte_count = count_q;
	assign last       = last_q;
	assign no_walk    = nowalk_out_q;

endmodule

`default_nettype wire

// ===== design/fcw_checker.sv =====
// port-level checks of the fat12 cluster chain walker, bound to the top level
// depends on fcw_pkg and fat12_cluster_chain_walker_top_defines.svh
`default_nettype none

`include "fat12_cluster_chain_walker_top_defines.svh"

module fcw_checker
	import fcw_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [FUNC_W-1:0]  func,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [SEC_W-1:0]   sector,
	input wire logic [CNT_W-1:0]   byte_count,
	input wire logic               last,
	input wire logic               no_walk
);

	// a stalled result holds its payload
	`FCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(sector) && $stable(byte_count) && $stable(last) &&
		$stable(no_walk), "stalled result changed")

	// a no-walk result carries nothing else
	`FCW_ASSERT_NOW(a_nowalk_zero, out_valid && no_walk,
		(sector == '0) && (byte_count == '0) && !last, "no_walk result not clean")

	// an empty sector always closes the walk
	`FCW_ASSERT_NOW(a_empty_last, out_valid && !no_walk && (byte_count == '0),
		last, "zero byte count without last")

	// a table write finishes in its transfer cycle
	`FCW_ASSERT_NEXT(a_write_one_cycle,
		in_valid && !in_stall && (func == FUNC_WRITE),
		!in_stall, "stall after a table write")

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.func       (func),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sector     (sector),
	.byte_count (byte_count),
	.last       (last),
	.no_walk    (no_walk)
);

`default_nettype wire
